// File: hw/rtl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// fhc_pkg
// Types and constants shared by the half/single converter pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhc_pkg;

  typedef enum logic {
    OP_S2H = 1'b0,
    OP_H2S = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLS_ZERO    = 2'd0,
    CLS_SUB     = 2'd1,
    CLS_NORM    = 2'd2,
    CLS_SPECIAL = 2'd3
  } cls_t;

  typedef struct packed {
    op_t         op;
    logic        sign;
    cls_t        cls;
    logic [7:0]  exp;
    logic [23:0] sig;
  } item_t;

  localparam logic [7:0]  EXP_REBIAS         = 8'd112;
  localparam logic [7:0]  SUB_EXP_BASE       = 8'd113;
  localparam logic [7:0]  TINY_EXP_MIN       = 8'd102;
  localparam logic [7:0]  SINGLE_EXP_SPECIAL = 8'hff;
  localparam logic [4:0]  HALF_EXP_SPECIAL   = 5'h1f;
  localparam logic [4:0]  HALF_EXP_ZERO      = 5'h00;
  localparam logic [7:0]  HALF_EXP_MAX       = 8'd30;
  localparam logic [7:0]  SUB_SHIFT_MIN      = 8'd1;
  localparam logic [7:0]  SUB_SHIFT_MAX      = 8'd10;
  localparam logic [23:0] ROUND_INC          = 24'h002000;
  localparam int          ROUND_BIT          = 12;
  localparam int          HALF_MANT_W        = 10;

endpackage

`default_nettype wire

// File: hw/rtl/fhc_decode.sv
// ----------------------------------------------------------------------------
// fhc_decode
// First stage: classify the source value, align single subnormals, find
// the normalize shift (leading zeros plus one) of half subnormals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhc_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fhc_pkg::op_t  op,
  input  wire logic [31:0]   value,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fhc_pkg::item_t     out_item
);

  fhc_pkg::item_t item_next;
  logic [7:0]     e8;
  logic [22:0]    mant;
  logic [4:0]     e5;
  logic [9:0]     m10;
  logic [7:0]     sh;
  logic [3:0]     k;

  assign e8   = value[30:23];
  assign mant = value[22:0];
  assign e5   = value[14:10];
  assign m10  = value[9:0];
  assign sh   = fhc_pkg::SUB_EXP_BASE - e8;

  always_comb begin
    k = 4'd0;
    for (int i = 0; i < fhc_pkg::HALF_MANT_W; i++) begin
      if (m10[i]) begin
        k = 4'(fhc_pkg::HALF_MANT_W - i);
      end
    end
  end

  always_comb begin
    item_next.op   = op;
    item_next.sign = (op == fhc_pkg::OP_H2S) ? value[15] : value[31];
    item_next.cls  = fhc_pkg::CLS_ZERO;
    item_next.exp  = 8'd0;
    item_next.sig  = 24'd0;
    if (op == fhc_pkg::OP_S2H) begin
      if (e8 == fhc_pkg::SINGLE_EXP_SPECIAL) begin
        item_next.cls = fhc_pkg::CLS_SPECIAL;
        item_next.sig = {1'b0, mant};
      end else if (e8 > fhc_pkg::EXP_REBIAS) begin
        item_next.cls = fhc_pkg::CLS_NORM;
        item_next.exp = e8 - fhc_pkg::EXP_REBIAS;
        item_next.sig = {1'b0, mant};
      end else if (e8 >= fhc_pkg::TINY_EXP_MIN) begin
        item_next.cls = fhc_pkg::CLS_SUB;
        item_next.sig = {1'b1, mant} >> sh[3:0];
      end
    end else begin
      if (e5 == fhc_pkg::HALF_EXP_ZERO) begin
        if (m10 != 10'd0) begin
          item_next.cls = fhc_pkg::CLS_SUB;
          item_next.exp = {4'd0, k};
          item_next.sig = {14'd0, m10};
        end
      end else if (e5 == fhc_pkg::HALF_EXP_SPECIAL) begin
        item_next.cls = fhc_pkg::CLS_SPECIAL;
        item_next.sig = {14'd0, m10};
      end else begin
        item_next.cls = fhc_pkg::CLS_NORM;
        item_next.exp = {3'd0, e5} + fhc_pkg::EXP_REBIAS;
        item_next.sig = {14'd0, m10};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fhc_round.sv
// ----------------------------------------------------------------------------
// fhc_round
// Second stage: round single mantissas half-up and fold carry and overflow;
// normalize half subnormals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhc_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fhc_pkg::item_t  in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fhc_pkg::item_t       out_item
);

  fhc_pkg::item_t item_next;
  logic [23:0]    r_sig;
  logic [7:0]     exp_inc;
  logic [7:0]     e_norm;
  logic [9:0]     shifted;

  assign r_sig   = in_item.sig + (in_item.sig[fhc_pkg::ROUND_BIT] ? fhc_pkg::ROUND_INC : 24'd0);
  assign exp_inc = in_item.exp + 8'd1;
  assign e_norm  = r_sig[23] ? exp_inc : in_item.exp;
  assign shifted = 10'(in_item.sig[9:0] << in_item.exp[3:0]);

  always_comb begin
    item_next = in_item;
    if (in_item.op == fhc_pkg::OP_S2H) begin
      case (in_item.cls)
        fhc_pkg::CLS_SUB: begin
          item_next.sig = r_sig;
        end
        fhc_pkg::CLS_NORM: begin
          item_next.exp = e_norm;
          item_next.sig = r_sig[23] ? 24'd0 : r_sig;
          if (e_norm > fhc_pkg::HALF_EXP_MAX) begin
            item_next.cls = fhc_pkg::CLS_SPECIAL;
            item_next.sig = 24'd0;
          end
        end
        default: begin
          item_next = in_item;
        end
      endcase
    end else if (in_item.cls == fhc_pkg::CLS_SUB) begin
      item_next.sig = {14'd0, shifted};
      item_next.exp = fhc_pkg::SUB_EXP_BASE - in_item.exp;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fhc_pack.sv
// ----------------------------------------------------------------------------
// fhc_pack
// Third stage: assemble the result bit pattern and hold it for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhc_pack (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fhc_pkg::item_t  in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          result
);

  logic [31:0] result_next;
  logic [9:0]  payload;
  logic        nan_fix;

  assign payload = in_item.sig[22:13];
  assign nan_fix = (in_item.sig != 24'd0) && (payload == 10'd0);

  always_comb begin
    result_next = 32'd0;
    if (in_item.op == fhc_pkg::OP_S2H) begin
      case (in_item.cls)
        fhc_pkg::CLS_ZERO:    result_next = {16'd0, in_item.sign, 15'd0};
        fhc_pkg::CLS_SUB:     result_next = {16'd0, in_item.sign, 4'd0, in_item.sig[23:13]};
        fhc_pkg::CLS_NORM:    result_next = {16'd0, in_item.sign, in_item.exp[4:0], payload};
        fhc_pkg::CLS_SPECIAL: result_next = {16'd0, in_item.sign, fhc_pkg::HALF_EXP_SPECIAL,
                                             payload[9:1], payload[0] | nan_fix};
        default:              result_next = 32'd0;
      endcase
    end else begin
      case (in_item.cls)
        fhc_pkg::CLS_ZERO:    result_next = {in_item.sign, 31'd0};
        fhc_pkg::CLS_SUB,
        fhc_pkg::CLS_NORM:    result_next = {in_item.sign, in_item.exp, in_item.sig[9:0], 13'd0};
        fhc_pkg::CLS_SPECIAL: result_next = {in_item.sign, fhc_pkg::SINGLE_EXP_SPECIAL,
                                             in_item.sig[9:0], 13'd0};
        default:              result_next = 32'd0;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/float_half_single_converter_unit.sv
// ----------------------------------------------------------------------------
// float_half_single_converter_unit
// Converts IEEE single and half precision bit patterns in either direction.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless the output stalls, through a
// three-stage register pipeline (decode and align, round or normalize,
// pack); the pipeline advances whenever the output is taken or empty,
// so a stall holds every stage without loss. tuser selects the
// direction: 0 converts single to half, 1 converts half to single. A half
// result sits in the low 16 bits with the upper bits zero; for half input
// the upper 16 bits of tdata are ignored. Rounding is half-up on the
// magnitude, tiny values flush to signed zero, NaNs keep a nonzero payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module float_half_single_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic        s_tuser,   // [0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [31:0] result
);

  fhc_pkg::item_t dec_item;
  fhc_pkg::item_t rnd_item;
  fhc_pkg::op_t   op;
  logic           dec_valid;
  logic           dec_ready;
  logic           rnd_valid;
  logic           rnd_ready;

  assign op = fhc_pkg::op_t'(s_tuser);

  fhc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (op),
    .value     (s_tdata),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_item  (dec_item)
  );

  fhc_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_item   (dec_item),
    .out_valid (rnd_valid),
    .out_ready (rnd_ready),
    .out_item  (rnd_item)
  );

  fhc_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rnd_valid),
    .in_ready  (rnd_ready),
    .in_item   (rnd_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (m_tdata)
  );

`ifndef SYNTHESIS
  a_backpressure_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (dec_valid && rnd_valid && m_tvalid))
    else $error("input stalled while a pipeline stage is empty");

  a_half_exp_range: assert property (@(posedge clk) disable iff (rst)
    (rnd_valid && rnd_item.op == fhc_pkg::OP_S2H && rnd_item.cls == fhc_pkg::CLS_NORM)
    |-> (rnd_item.exp <= fhc_pkg::HALF_EXP_MAX && rnd_item.exp != 8'd0))
    else $error("normal half exponent out of range after rounding");

  a_sub_shift_range: assert property (@(posedge clk) disable iff (rst)
    (dec_valid && dec_item.op == fhc_pkg::OP_H2S && dec_item.cls == fhc_pkg::CLS_SUB)
    |-> (dec_item.exp >= fhc_pkg::SUB_SHIFT_MIN && dec_item.exp <= fhc_pkg::SUB_SHIFT_MAX))
    else $error("half subnormal normalize shift out of range");
`endif

endmodule

`default_nettype wire
